[hw/rtl/bepg_pkg.sv]
package bepg_pkg;

  localparam int CP_W    = 21;
  localparam int PIX_W   = 8;
  localparam int LEVEL_W = 8;
  localparam int REG_W   = 9;

  // U+2580 .. U+259F share every code point bit above the low five
  localparam logic [CP_W-6:0] BLOCK_PAGE = 16'h012C;

  localparam logic [LEVEL_W-1:0] LEVEL_EMPTY  = 8'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LIGHT  = 8'd64;
  localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM = 8'd128;
  localparam logic [LEVEL_W-1:0] LEVEL_DARK   = 8'd191;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 8'd255;

  // rectangle corners in eighths of the cell
  typedef struct packed {
    logic [3:0] x0;
    logic [3:0] y0;
    logic [3:0] x1;
    logic [3:0] y1;
  } rect_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] shade;
    logic [1:0]         count;
    rect_t              ra;
    rect_t              rb;
  } glyph_t;

  function automatic rect_t mk_rect(logic [3:0] x0, logic [3:0] y0,
                                    logic [3:0] x1, logic [3:0] y1);
    rect_t r;
    r.x0 = x0;
    r.y0 = y0;
    r.x1 = x1;
    r.y1 = y1;
    return r;
  endfunction

  function automatic glyph_t mk_glyph(logic [LEVEL_W-1:0] shade, logic [1:0] count,
                                      rect_t ra, rect_t rb);
    glyph_t g;
    g.shade = shade;
    g.count = count;
    g.ra    = ra;
    g.rb    = rb;
    return g;
  endfunction

  function automatic glyph_t glyph_lookup(logic [4:0] idx);
    rect_t  z;
    glyph_t g;
    z = mk_rect(4'd0, 4'd0, 4'd0, 4'd0);
    case (idx)
      5'h00: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd0, 4'd8, 4'd4), z);
      5'h01: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd7, 4'd8, 4'd8), z);
      5'h02: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd6, 4'd8, 4'd8), z);
      5'h03: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd5, 4'd8, 4'd8), z);
      5'h04: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd4, 4'd8, 4'd8), z);
      5'h05: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd3, 4'd8, 4'd8), z);
      5'h06: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd2, 4'd8, 4'd8), z);
      5'h07: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd1, 4'd8, 4'd8), z);
      5'h08: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd0, 4'd8, 4'd8), z);
      5'h09: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd0, 4'd7, 4'd8), z);
      5'h0A: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd0, 4'd6, 4'd8), z);
      5'h0B: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd0, 4'd5, 4'd8), z);
      5'h0C: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd0, 4'd4, 4'd8), z);
      5'h0D: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd0, 4'd3, 4'd8), z);
      5'h0E: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd0, 4'd2, 4'd8), z);
      5'h0F: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd0, 4'd1, 4'd8), z);
      5'h10: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd4, 4'd0, 4'd8, 4'd8), z);
      5'h11: g = mk_glyph(LEVEL_LIGHT, 2'd0, z, z);
      5'h12: g = mk_glyph(LEVEL_MEDIUM, 2'd0, z, z);
      5'h13: g = mk_glyph(LEVEL_DARK, 2'd0, z, z);
      5'h14: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd0, 4'd8, 4'd1), z);
      5'h15: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd7, 4'd0, 4'd8, 4'd8), z);
      5'h16: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd4, 4'd4, 4'd8), z);
      5'h17: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd4, 4'd4, 4'd8, 4'd8), z);
      5'h18: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd0, 4'd0, 4'd4, 4'd4), z);
      5'h19: g = mk_glyph(LEVEL_EMPTY, 2'd2, mk_rect(4'd0, 4'd0, 4'd4, 4'd4),
                          mk_rect(4'd0, 4'd4, 4'd8, 4'd8));
      5'h1A: g = mk_glyph(LEVEL_EMPTY, 2'd2, mk_rect(4'd0, 4'd0, 4'd4, 4'd4),
                          mk_rect(4'd4, 4'd4, 4'd8, 4'd8));
      5'h1B: g = mk_glyph(LEVEL_EMPTY, 2'd2, mk_rect(4'd0, 4'd0, 4'd8, 4'd4),
                          mk_rect(4'd0, 4'd4, 4'd4, 4'd8));
      5'h1C: g = mk_glyph(LEVEL_EMPTY, 2'd2, mk_rect(4'd0, 4'd0, 4'd8, 4'd4),
                          mk_rect(4'd4, 4'd4, 4'd8, 4'd8));
      5'h1D: g = mk_glyph(LEVEL_EMPTY, 2'd1, mk_rect(4'd4, 4'd0, 4'd8, 4'd4), z);
      5'h1E: g = mk_glyph(LEVEL_EMPTY, 2'd2, mk_rect(4'd4, 4'd0, 4'd8, 4'd4),
                          mk_rect(4'd0, 4'd4, 4'd4, 4'd8));
      5'h1F: g = mk_glyph(LEVEL_EMPTY, 2'd2, mk_rect(4'd4, 4'd0, 4'd8, 4'd4),
                          mk_rect(4'd0, 4'd4, 4'd8, 4'd8));
      default: g = mk_glyph(LEVEL_EMPTY, 2'd0, z, z);
    endcase
    return g;
  endfunction

endpackage

[hw/rtl/bepg_cfg.sv]
module bepg_cfg #(
  parameter int MAX_CELL_DIM = 256,
  parameter int DIM_W        = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [DIM_W-1:0] box_w,
  output logic [DIM_W-1:0] box_h
);
  import bepg_pkg::*;

  localparam logic REG_BOX_W = 1'b0;
  localparam logic REG_BOX_H = 1'b1;

  localparam int          CAP_INT = (MAX_CELL_DIM > 511) ? 511 : MAX_CELL_DIM;
  localparam logic [REG_W-1:0] DIM_CAP = REG_W'(CAP_INT);
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'((CAP_INT < 8) ? CAP_INT : 8);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'((CAP_INT < 16) ? CAP_INT : 16);

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [REG_W-1:0] wr_raw;
  logic [REG_W-1:0] wr_sat;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];
  assign wr_raw  = pwdata[REG_W-1:0];
  assign wr_sat  = (wr_raw > DIM_CAP) ? DIM_CAP : wr_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_BOX_W: width_r  <= wr_sat[DIM_W-1:0];
        REG_BOX_H: height_r <= wr_sat[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BOX_W: prdata = 32'(width_r);
      REG_BOX_H: prdata = 32'(height_r);
      default:   prdata = '0;
    endcase
  end

  assign box_w = width_r;
  assign box_h = height_r;

endmodule

[hw/rtl/bepg_raster.sv]
module bepg_raster #(
  parameter int DIM_W = 9
) (
  input  logic [20:0]      code_point,
  input  logic [7:0]       pixel_x,
  input  logic [7:0]       pixel_y,
  input  logic [DIM_W-1:0] box_w,
  input  logic [DIM_W-1:0] box_h,
  output logic [7:0]       intensity,
  output logic             is_block_element
);
  import bepg_pkg::*;

  localparam int CMP_W = (DIM_W > PIX_W) ? DIM_W : PIX_W;

  // floor(dim * k / 8)
  function automatic logic [CMP_W-1:0] bound_of(logic [DIM_W-1:0] dim, logic [3:0] k);
    logic [DIM_W+3:0] prod;
    prod = (DIM_W+4)'(dim) * (DIM_W+4)'(k);
    return CMP_W'(prod[DIM_W+2:3]);
  endfunction

  function automatic logic in_rect(rect_t r, logic [CMP_W-1:0] x, logic [CMP_W-1:0] y,
                                   logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    logic hit_x;
    logic hit_y;
    hit_x = (x >= bound_of(w, r.x0)) && (x < bound_of(w, r.x1));
    hit_y = (y >= bound_of(h, r.y0)) && (y < bound_of(h, r.y1));
    return hit_x & hit_y;
  endfunction

  glyph_t           glyph;
  logic [CMP_W-1:0] px;
  logic [CMP_W-1:0] py;
  logic             in_page;
  logic             in_cell;
  logic             hit;

  assign glyph   = glyph_lookup(code_point[4:0]);
  assign px      = CMP_W'(pixel_x);
  assign py      = CMP_W'(pixel_y);
  assign in_page = (code_point[CP_W-1:5] == BLOCK_PAGE);
  assign in_cell = (px < CMP_W'(box_w)) && (py < CMP_W'(box_h));

  always_comb begin
    hit = 1'b0;
    if (glyph.count != 2'd0) begin
      hit = in_rect(glyph.ra, px, py, box_w, box_h);
    end
    if (glyph.count == 2'd2) begin
      hit = hit | in_rect(glyph.rb, px, py, box_w, box_h);
    end
  end

  always_comb begin
    is_block_element = in_page & in_cell;
    intensity        = LEVEL_EMPTY;
    if (is_block_element) begin
      if (glyph.shade != LEVEL_EMPTY) begin
        intensity = glyph.shade;
      end else if (hit) begin
        intensity = LEVEL_FULL;
      end
    end
  end

endmodule

[hw/rtl/block_element_pixel_generator.sv]
// block element pixel generator
//
// draws one pixel of a glyph from U+2580..U+259F in a cell of
// box_w x box_h pixels (registers 0 and 1 of the apb port)
// input channel: in_code_point, in_pixel_x, in_pixel_y with in_valid and
// in_stall; a request is taken when in_valid is high and in_stall is low
// output channel: out_intensity, out_is_block_element with out_valid and
// out_stall, one result for every request, in order
// the pipeline is an input register, then the glyph table lookup and
// edge compares feeding the result register
// one request per cycle when not stalled, set by that single compare stage
// when the receiver stalls, the result register holds and the input
// register fills; in_stall rises only once both are occupied
// reset clears both valid flags and loads width 8 and height 16
// user writes registers only while no request is in flight; not enforced
module block_element_pixel_generator #(
  parameter int MAX_CELL_DIM = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [20:0] in_code_point,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_intensity,
  output logic        out_is_block_element,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bepg_pkg::*;

  localparam int DIM_NEED = $clog2(MAX_CELL_DIM + 1);
  localparam int DIM_W    = (DIM_NEED < REG_W) ? DIM_NEED : REG_W;

  logic [DIM_W-1:0] box_w;
  logic [DIM_W-1:0] box_h;

  logic               s1_valid_r;
  logic [CP_W-1:0]    s1_cp_r;
  logic [PIX_W-1:0]   s1_x_r;
  logic [PIX_W-1:0]   s1_y_r;
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_intensity_r;
  logic               out_flag_r;
  logic [LEVEL_W-1:0] intensity_nxt;
  logic               flag_nxt;
  logic               out_adv;
  logic               in_take;

  bepg_cfg #(
    .MAX_CELL_DIM (MAX_CELL_DIM),
    .DIM_W        (DIM_W)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .box_w   (box_w),
    .box_h   (box_h)
  );

  bepg_raster #(
    .DIM_W (DIM_W)
  ) u_raster (
    .code_point       (s1_cp_r),
    .pixel_x          (s1_x_r),
    .pixel_y          (s1_y_r),
    .box_w            (box_w),
    .box_h            (box_h),
    .intensity        (intensity_nxt),
    .is_block_element (flag_nxt)
  );

  assign out_adv  = ~out_valid_r | ~out_stall;
  assign in_stall = s1_valid_r & ~out_adv;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cp_r <= in_code_point;
      s1_x_r  <= in_pixel_x;
      s1_y_r  <= in_pixel_y;
    end
    if (out_adv && s1_valid_r) begin
      out_intensity_r <= intensity_nxt;
      out_flag_r      <= flag_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_intensity        = out_intensity_r;
  assign out_is_block_element = out_flag_r;

endmodule

[hw/rtl/bepg_checker.sv]
module bepg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_intensity,
  input logic       out_is_block_element
);

  // result register held under stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // with an empty result register the pipe always has room
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_outside_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_block_element |-> out_intensity == 8'd0)
    else $error("lit pixel outside glyph range");

  a_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_block_element |->
      (out_intensity == 8'd0 || out_intensity == 8'd64 || out_intensity == 8'd128 ||
       out_intensity == 8'd191 || out_intensity == 8'd255))
    else $error("unexpected intensity level");

endmodule

bind block_element_pixel_generator bepg_checker u_bepg_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_intensity        (out_intensity),
  .out_is_block_element (out_is_block_element)
);

[test/tb_block_element_pixel_generator.sv]
`timescale 1ns / 100ps

module tb_block_element_pixel_generator;
  import bepg_pkg::*;

  localparam logic [20:0] BLOCK_FIRST = 21'h2580;
  localparam logic [20:0] BLOCK_LAST  = 21'h259F;
  localparam logic [4:0]  GLYPH_LIGHT  = 5'h11;
  localparam logic [4:0]  GLYPH_MEDIUM = 5'h12;
  localparam logic [4:0]  GLYPH_DARK   = 5'h13;
  localparam int unsigned REG_BOX_W    = 0;
  localparam int unsigned REG_BOX_H    = 1;
  localparam int unsigned CELL_DIM_MAX    = 256;
  localparam int unsigned HOLD_CYCLES     = 200;
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned PHASES          = 10;

  typedef struct packed {
    logic [20:0] cp;
    logic [7:0]  x;
    logic [7:0]  y;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] level;
    logic       in_block;
  } pixel_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [20:0] in_code_point = '0;
  logic [7:0]  in_pixel_x = '0;
  logic [7:0]  in_pixel_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_intensity;
  logic        out_is_block_element;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_req_t  pixel_q [$];
  pixel_res_t  intensity_q [$];
  int unsigned cur_width = 8;
  int unsigned cur_height = 16;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  logic        in_fire = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          send_idle_on = 1'b0;
  bit          recv_idle_on = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned holds_done = 0;

  block_element_pixel_generator u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_code_point        (in_code_point),
    .in_pixel_x           (in_pixel_x),
    .in_pixel_y           (in_pixel_y),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_intensity        (out_intensity),
    .out_is_block_element (out_is_block_element),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // two rectangles per glyph, nibbles x0 y0 x1 y1 in eighths
  function automatic logic [31:0] glyph_rects(logic [4:0] g);
    case (g)
      5'h00: return {16'h0084, 16'h0000};
      5'h01: return {16'h0788, 16'h0000};
      5'h02: return {16'h0688, 16'h0000};
      5'h03: return {16'h0588, 16'h0000};
      5'h04: return {16'h0488, 16'h0000};
      5'h05: return {16'h0388, 16'h0000};
      5'h06: return {16'h0288, 16'h0000};
      5'h07: return {16'h0188, 16'h0000};
      5'h08: return {16'h0088, 16'h0000};
      5'h09: return {16'h0078, 16'h0000};
      5'h0A: return {16'h0068, 16'h0000};
      5'h0B: return {16'h0058, 16'h0000};
      5'h0C: return {16'h0048, 16'h0000};
      5'h0D: return {16'h0038, 16'h0000};
      5'h0E: return {16'h0028, 16'h0000};
      5'h0F: return {16'h0018, 16'h0000};
      5'h10: return {16'h4088, 16'h0000};
      5'h14: return {16'h0081, 16'h0000};
      5'h15: return {16'h7088, 16'h0000};
      5'h16: return {16'h0448, 16'h0000};
      5'h17: return {16'h4488, 16'h0000};
      5'h18: return {16'h0044, 16'h0000};
      5'h19: return {16'h0044, 16'h0488};
      5'h1A: return {16'h0044, 16'h4488};
      5'h1B: return {16'h0084, 16'h0448};
      5'h1C: return {16'h0084, 16'h4488};
      5'h1D: return {16'h4084, 16'h0000};
      5'h1E: return {16'h4084, 16'h0448};
      5'h1F: return {16'h4084, 16'h0488};
      default: return 32'h0;
    endcase
  endfunction

  function automatic bit rect_hit(logic [15:0] r, int unsigned x, int unsigned y);
    int unsigned x0, y0, x1, y1;
    x0 = (cur_width * r[15:12]) / 8;
    y0 = (cur_height * r[11:8]) / 8;
    x1 = (cur_width * r[7:4]) / 8;
    y1 = (cur_height * r[3:0]) / 8;
    return x >= x0 && x < x1 && y >= y0 && y < y1;
  endfunction

  function automatic pixel_res_t glyph_pixel(pixel_req_t req);
    pixel_res_t  res;
    logic [31:0] rects;
    res.level    = LEVEL_EMPTY;
    res.in_block = 1'b0;
    if (req.cp >= BLOCK_FIRST && req.cp <= BLOCK_LAST &&
        req.x < cur_width && req.y < cur_height) begin
      res.in_block = 1'b1;
      rects = glyph_rects(req.cp[4:0]);
      case (req.cp[4:0])
        GLYPH_LIGHT: res.level = LEVEL_LIGHT;
        GLYPH_MEDIUM: res.level = LEVEL_MEDIUM;
        GLYPH_DARK: res.level = LEVEL_DARK;
        default: begin
          if (rect_hit(rects[31:16], req.x, req.y) || rect_hit(rects[15:0], req.x, req.y))
            res.level = LEVEL_FULL;
        end
      endcase
    end
    return res;
  endfunction

  function automatic int unsigned clamp_cell_dim(logic [31:0] v);
    int unsigned m;
    m = v[8:0];
    return (m > CELL_DIM_MAX) ? CELL_DIM_MAX : m;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_coord(int unsigned dim);
    int unsigned s, e;
    s = $urandom_range(0, 99);
    if (dim > 0 && s < 65) return 8'($urandom_range(0, dim - 1));
    if (dim > 0 && s < 85) begin
      e = (dim * $urandom_range(0, 8)) / 8;
      if (e > 0 && $urandom_range(0, 1) == 1) e = e - 1;
      if (e > 255) e = 255;
      return 8'(e);
    end
    return 8'($urandom);
  endfunction

  function automatic logic [20:0] pick_code();
    int unsigned s;
    s = $urandom_range(0, 99);
    if (s < 80) return BLOCK_FIRST + 21'($urandom_range(0, 31));
    if (s < 90) return BLOCK_FIRST - 21'd32 + 21'($urandom_range(0, 95));
    if (s < 95) return BLOCK_FIRST | 21'($urandom_range(1, 31) << 16);
    return 21'($urandom);
  endfunction

  task automatic push_pixel(logic [20:0] cp, logic [7:0] x, logic [7:0] y);
    pixel_req_t req;
    req.cp = cp;
    req.x  = x;
    req.y  = y;
    pixel_q.push_back(req);
  endtask

  task automatic apb_access(bit wr, int unsigned idx, logic [31:0] data);
    logic [31:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= 3'(idx << 2);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (wr) begin
      if (idx == REG_BOX_W) cur_width = clamp_cell_dim(data);
      else cur_height = clamp_cell_dim(data);
    end else begin
      want = (idx == REG_BOX_W) ? cur_width : cur_height;
      if (prdata !== want) begin
        $error("prdata: expected %0d, actual %0d", want, prdata);
        fail_count++;
      end
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pixel_q.size() != 0 || in_valid || intensity_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin : feed
    pixel_req_t nxt;
    if (in_fire || !in_valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        nxt = pixel_q.pop_front();
        in_code_point <= nxt.cp;
        in_pixel_x    <= nxt.x;
        in_pixel_y    <= nxt.y;
        in_valid      <= 1'b1;
        send_gap      <= send_idle_on ? idle_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  always @(negedge clk) begin : drain
    int unsigned len;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (holds_done != hold_reqs) begin
      holds_done <= holds_done + 1;
      stall_left <= HOLD_CYCLES - 1;
      out_stall  <= 1'b1;
    end else if (recv_idle_on) begin
      len = idle_len();
      out_stall  <= (len != 0);
      stall_left <= (len != 0) ? len - 1 : 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // prediction on accepted requests, checking of accepted results
  always @(posedge clk) begin : score
    pixel_res_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      intensity_q.push_back(glyph_pixel(pixel_req_t'({in_code_point, in_pixel_x, in_pixel_y})));
    if (rst_n && out_valid && !out_stall) begin
      if (intensity_q.size() == 0) begin
        $error("out_intensity: expected none, actual %0d", out_intensity);
        fail_count++;
      end else begin
        want = intensity_q.pop_front();
        if (out_intensity !== want.level) begin
          $error("out_intensity: expected %0d, actual %0d", want.level, out_intensity);
          fail_count++;
        end
        if (out_is_block_element !== want.in_block) begin
          $error("out_is_block_element: expected %0d, actual %0d", want.in_block,
                 out_is_block_element);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned wlist [PHASES];
    int unsigned hlist [PHASES];
    int unsigned p, n;
    wlist = '{8, 1, 256, 0, 16, 300, 7, 32'h0000_0A10, 0, 0};
    hlist = '{16, 1, 256, 16, 0, 511, 13, 3, 0, 0};
    wlist[8] = $urandom_range(1, 256);
    hlist[8] = $urandom_range(1, 256);
    wlist[9] = $urandom_range(257, 511);
    hlist[9] = $urandom_range(1, 40);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    apb_access(1'b0, REG_BOX_W, '0);
    apb_access(1'b0, REG_BOX_H, '0);

    // directed, reset cell of 8 x 16
    push_pixel(21'h2580, 8'd0, 8'd0);
    push_pixel(21'h2580, 8'd7, 8'd7);
    push_pixel(21'h2580, 8'd0, 8'd8);
    push_pixel(21'h257F, 8'd0, 8'd0);
    push_pixel(21'h25A0, 8'd0, 8'd0);
    push_pixel(21'h259F, 8'd7, 8'd15);
    push_pixel(21'h2591, 8'd3, 8'd3);
    push_pixel(21'h2592, 8'd0, 8'd15);
    push_pixel(21'h2593, 8'd7, 8'd15);
    push_pixel(21'h2593, 8'd8, 8'd0);
    push_pixel(21'h2588, 8'd255, 8'd255);
    push_pixel(21'h2588, 8'd0, 8'd16);
    push_pixel(21'h1FFFFF, 8'd255, 8'd255);
    push_pixel(21'h000000, 8'd0, 8'd0);
    push_pixel(21'h012580, 8'd0, 8'd0);
    push_pixel(21'h2599, 8'd2, 8'd2);
    push_pixel(21'h2599, 8'd6, 8'd2);
    push_pixel(21'h259A, 8'd5, 8'd12);
    push_pixel(21'h2595, 8'd7, 8'd0);
    push_pixel(21'h2595, 8'd6, 8'd0);
    push_pixel(21'h2581, 8'd0, 8'd13);
    push_pixel(21'h2581, 8'd0, 8'd14);
    push_pixel(21'h2594, 8'd4, 8'd1);
    wait_drain();

    for (p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        apb_access(1'b1, REG_BOX_W, wlist[p]);
        apb_access(1'b1, REG_BOX_H, hlist[p]);
        apb_access(1'b0, REG_BOX_W, '0);
        apb_access(1'b0, REG_BOX_H, '0);
      end
      send_idle_on = (p % 3 != 0);
      recv_idle_on = (p % 4 != 1);
      if (p == 2 || p == 6) hold_reqs++;
      for (n = 0; n < 200; n++) push_pixel(pick_code(), pick_coord(cur_width),
                                           pick_coord(cur_height));
      wait_drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
